// ===== src/vimr_pkg.sv =====
// ---------------------------------------------------------------------------
// vimr_pkg: shared definitions for the virtio-mmio input register unit
// Payload structs, register offsets, command codes, controller state type and
// the functions that produce the rebuilt config space contents.
// ---------------------------------------------------------------------------
package vimr_pkg;

  // Default size of the device config space in bytes.
  localparam int CONFIG_BYTES_DEF = 256;

  // Queue size reported at the queue size register.
  localparam logic [31:0] QUEUE_DEPTH = 32'd128;

  // Identity words.
  localparam logic [31:0] MAGIC_VALUE  = 32'h7472_6976;
  localparam logic [31:0] VERSION_VAL  = 32'd2;
  localparam logic [31:0] DEVICE_ID    = 32'd18;
  localparam logic [31:0] VENDOR_VALUE = 32'h554D_4551;

  // Request command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_IRQ   = 2'd2;

  // Register offsets in the window.
  localparam logic [8:0] OFF_MAGIC       = 9'h000;
  localparam logic [8:0] OFF_VERSION     = 9'h004;
  localparam logic [8:0] OFF_DEVICE_ID   = 9'h008;
  localparam logic [8:0] OFF_VENDOR      = 9'h00C;
  localparam logic [8:0] OFF_FEATURES    = 9'h010;
  localparam logic [8:0] OFF_FEAT_SEL    = 9'h014;
  localparam logic [8:0] OFF_QUEUE_SEL   = 9'h030;
  localparam logic [8:0] OFF_QUEUE_MAX   = 9'h034;
  localparam logic [8:0] OFF_QUEUE_READY = 9'h044;
  localparam logic [8:0] OFF_NOTIFY      = 9'h050;
  localparam logic [8:0] OFF_IRQ_STATUS  = 9'h060;
  localparam logic [8:0] OFF_IRQ_ACK     = 9'h064;
  localparam logic [8:0] OFF_STATUS      = 9'h070;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_KIND = 2'd0;
  localparam logic [1:0] CFG_AXIS_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_AXIS_HEIGHT = 2'd2;

  // Config space select codes.
  localparam logic [7:0] SEL_NAME     = 8'h01;
  localparam logic [7:0] SEL_EV_BITS  = 8'h11;
  localparam logic [7:0] SEL_ABS_INFO = 8'h12;

  // Rebuilt region: bytes 8..135, then the size byte at 2.
  localparam int RB_BASE  = 8;
  localparam int RB_BYTES = 128;
  localparam int SIZE_POS = 2;

  // Device names.
  localparam int KBD_LEN = 15;
  localparam int TAB_LEN = 13;
  localparam logic [8*KBD_LEN-1:0] KBD_NAME = "virtio-keyboard";
  localparam logic [8*TAB_LEN-1:0] TAB_NAME = "virtio-tablet";

  typedef struct packed {
    logic [1:0]  cmd;
    logic [8:0]  offset;
    logic [31:0] write_data;
    logic [2:0]  access_bytes;
  } vimr_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        notify_valid;
    logic        notify_queue;
    logic        device_reset;
    logic        irq_pending;
  } vimr_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WR_BYTE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_REBUILD,
    ST_DONE
  } vimr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic load;
    logic reg_op;
    logic clear_en;
    logic wr_byte;
    logic rd_issue;
    logic rd_capture;
    logic rb_en;
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;
  } vimr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_reg_op;
    logic is_cfg_read;
    logic n_zero;
    logic byte_last;
    logic need_rebuild;
    logic clear_last;
    logic rebuild_last;
    logic out_free;
  } vimr_stat_t;

  // Byte 8+k of the rebuilt config space.
  function automatic logic [7:0] rebuild_byte(input logic [7:0] sel, input logic [7:0] sub,
                                              input logic tablet, input logic [31:0] aw,
                                              input logic [31:0] ah, input logic [6:0] k);
    logic [7:0]  b;
    logic [31:0] v;
    b = '0;
    v = (sub == 8'd0) ? aw : ah;
    unique case (sel)
      SEL_NAME: begin
        if (tablet) begin
          if (k < 7'(TAB_LEN)) b = TAB_NAME[8*(TAB_LEN-1-int'(k)) +: 8];
        end else begin
          if (k < 7'(KBD_LEN)) b = KBD_NAME[8*(KBD_LEN-1-int'(k)) +: 8];
        end
      end
      SEL_EV_BITS: begin
        if (sub == 8'd0) begin
          if (k == 7'd0) b = 8'h01;
        end else if (sub == 8'd1) begin
          // Keyboard reports every key; tablet reports three buttons.
          if (!tablet) b = 8'hFF;
          else if (k == 7'd34) b = 8'h07;
        end else if (sub == 8'd3 && tablet) begin
          if (k == 7'd0) b = 8'h03;
        end
      end
      SEL_ABS_INFO: begin
        // Only the maximum field (bytes 12..15) is nonzero.
        if (tablet && (sub == 8'd0 || sub == 8'd1) && k >= 7'd4 && k <= 7'd7)
          b = v[{k[1:0], 3'b000} +: 8];
      end
      default: b = '0;
    endcase
    return b;
  endfunction

  // Size byte of the rebuilt config space.
  function automatic logic [7:0] rebuild_size(input logic [7:0] sel, input logic [7:0] sub,
                                              input logic tablet);
    logic [7:0] s;
    s = '0;
    unique case (sel)
      SEL_NAME: s = tablet ? 8'(TAB_LEN) : 8'(KBD_LEN);
      SEL_EV_BITS: begin
        if (sub == 8'd0) s = 8'd1;
        else if (sub == 8'd1) s = tablet ? 8'd35 : 8'd128;
        else if (sub == 8'd3 && tablet) s = 8'd1;
      end
      SEL_ABS_INFO: begin
        if (tablet && (sub == 8'd0 || sub == 8'd1)) s = 8'd20;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/vimr_ctrl.sv =====
// ---------------------------------------------------------------------------
// vimr_ctrl: sequencer of the virtio-mmio input register unit
// Steps one request at a time through register decode, byte-wide config
// reads and writes, the config rebuild sweep and the result handoff.
// ---------------------------------------------------------------------------
module vimr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  vimr_pkg::vimr_stat_t stat,
  output vimr_pkg::vimr_cmd_t  cmd
);
  import vimr_pkg::*;

  vimr_state_t state, state_next;

  // State register; reset starts the clearing sweep of the config space.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (req_valid) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_reg_op) begin
          cmd.reg_op = 1'b1;
          state_next = ST_DONE;
        end else if (stat.is_cfg_read) begin
          state_next = stat.n_zero ? ST_DONE : ST_RD_ADDR;
        end else if (!stat.n_zero) begin
          state_next = ST_WR_BYTE;
        end else begin
          state_next = stat.need_rebuild ? ST_REBUILD : ST_DONE;
        end
      end
      ST_WR_BYTE: begin
        cmd.wr_byte = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.byte_last) begin
          if (stat.need_rebuild) begin
            cmd.cnt_inc = 1'b0;
            cmd.cnt_clr = 1'b1;
            state_next  = ST_REBUILD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd.rd_capture = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_next     = stat.byte_last ? ST_DONE : ST_RD_ADDR;
      end
      ST_REBUILD: begin
        cmd.rb_en   = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.rebuild_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A rebuild is only entered from a config write.
  a_rebuild_from_write: assert property (@(posedge clk) disable iff (rst)
    (state_next == ST_REBUILD && state != ST_REBUILD) |->
      (stat.need_rebuild && (state == ST_EXEC || state == ST_WR_BYTE)))
    else $error("rebuild started without a select write");

  // A request is loaded only when the previous result has been handed off.
  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_EXEC && !cmd.load)
    else $error("request load outside idle");

  // The clearing sweep runs only right after reset.
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && !$past(rst)) |-> $past(state) == ST_CLEAR)
    else $error("clearing sweep entered outside reset");

endmodule

// ===== src/vimr_dp.sv =====
// ---------------------------------------------------------------------------
// vimr_dp: datapath of the virtio-mmio input register unit
// Holds the request, the device registers, the config space memory with its
// sweep counter, and the result register facing the output channel.
// ---------------------------------------------------------------------------
module vimr_dp #(
  parameter int CONFIG_BYTES = vimr_pkg::CONFIG_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  vimr_pkg::vimr_req_t  req,
  input  vimr_pkg::vimr_cmd_t  cmd,
  output vimr_pkg::vimr_stat_t stat,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output vimr_pkg::vimr_rsp_t  rsp
);
  import vimr_pkg::*;

  localparam int AW = $clog2(CONFIG_BYTES);
  localparam int CW = $clog2(CONFIG_BYTES + 1);

  // Configuration registers.
  logic        device_kind;
  logic [31:0] axis_width;
  logic [31:0] axis_height;

  // Device registers.
  logic [31:0] feature_select;
  logic        queue_index;
  logic [1:0]  queue_ready;
  logic [31:0] irq_status;
  logic [31:0] device_status;

  // Mirrors of config bytes 0 (select) and 1 (subselect).
  logic [7:0] sel_byte;
  logic [7:0] sub_byte;

  // Request and result state.
  vimr_req_t   req_r;
  logic [31:0] rd_acc;
  logic        nv;
  logic        nq;
  logic        drst;
  logic [CW-1:0] cnt;

  // Config space memory.
  logic [7:0]    cfg_mem [CONFIG_BYTES];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Decode of the held request.
  logic          in_cfg;
  logic [AW-1:0] c_off;
  logic [8:0]    remain;
  logic [2:0]    len4;
  logic [2:0]    n_bytes;
  logic          is_read;
  logic          is_write;
  logic [31:0]   reg_rd;

  assign is_read  = req_r.cmd == CMD_READ;
  assign is_write = req_r.cmd == CMD_WRITE;
  assign in_cfg   = req_r.offset[8] && ({1'b0, req_r.offset[7:0]} < 9'(CONFIG_BYTES));
  assign c_off    = req_r.offset[AW-1:0];
  assign remain   = 9'(CONFIG_BYTES) - {1'b0, req_r.offset[7:0]};
  assign len4     = (req_r.access_bytes > 3'd4) ? 3'd4 : req_r.access_bytes;
  assign n_bytes  = !in_cfg ? 3'd0 : (remain < {6'b0, len4}) ? remain[2:0] : len4;

  // Status toward the controller.
  always_comb begin
    stat.is_reg_op    = !(in_cfg && (is_read || is_write));
    stat.is_cfg_read  = in_cfg && is_read;
    stat.n_zero       = n_bytes == 3'd0;
    stat.byte_last    = (cnt[2:0] + 3'd1) == n_bytes;
    stat.need_rebuild = in_cfg && is_write && (c_off <= AW'(1));
    stat.clear_last   = cnt == CW'(CONFIG_BYTES - 1);
    stat.rebuild_last = cnt == CW'(RB_BYTES);
    stat.out_free     = !rsp_valid || !rsp_stall;
  end

  // Sweep and byte counter.
  always_ff @(posedge clk) begin
    if (rst)              cnt <= '0;
    else if (cmd.cnt_clr) cnt <= '0;
    else if (cmd.cnt_inc) cnt <= cnt + CW'(1);
  end

  // Request holding register.
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_kind <= 1'b0;
      axis_width  <= '0;
      axis_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEVICE_KIND: device_kind <= cfg_data[0];
        CFG_AXIS_WIDTH:  axis_width  <= cfg_data;
        CFG_AXIS_HEIGHT: axis_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Device register updates for register writes and completions.
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_select <= '0;
      queue_index    <= 1'b0;
      queue_ready    <= '0;
      irq_status     <= '0;
      device_status  <= '0;
    end else if (cmd.reg_op) begin
      if (is_write && !in_cfg) begin
        unique case (req_r.offset)
          OFF_FEAT_SEL:    feature_select <= req_r.write_data;
          OFF_QUEUE_SEL:   queue_index    <= req_r.write_data != '0;
          OFF_QUEUE_READY: queue_ready[queue_index] <= req_r.write_data != '0;
          OFF_IRQ_ACK:     irq_status     <= irq_status & ~req_r.write_data;
          OFF_STATUS: begin
            device_status <= req_r.write_data;
            if (req_r.write_data == '0) begin
              queue_ready <= '0;
              irq_status  <= '0;
            end
          end
          default: ;
        endcase
      end else if (req_r.cmd == CMD_IRQ) begin
        irq_status[0] <= 1'b1;
      end
    end
  end

  // Register read multiplexer.
  always_comb begin
    reg_rd = '0;
    unique case (req_r.offset)
      OFF_MAGIC:       reg_rd = MAGIC_VALUE;
      OFF_VERSION:     reg_rd = VERSION_VAL;
      OFF_DEVICE_ID:   reg_rd = DEVICE_ID;
      OFF_VENDOR:      reg_rd = VENDOR_VALUE;
      OFF_FEATURES:    reg_rd = {31'd0, feature_select == 32'd1};
      OFF_QUEUE_MAX:   reg_rd = QUEUE_DEPTH;
      OFF_QUEUE_READY: reg_rd = {31'd0, queue_ready[queue_index]};
      OFF_IRQ_STATUS:  reg_rd = irq_status;
      OFF_STATUS:      reg_rd = device_status;
      default:         reg_rd = '0;
    endcase
  end

  // Result fields, built up while the request is worked on.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_acc <= '0;
      nv     <= 1'b0;
      nq     <= 1'b0;
      drst   <= 1'b0;
    end else if (cmd.reg_op) begin
      if (is_read && !in_cfg) rd_acc <= reg_rd;
      if (is_write && !in_cfg && req_r.offset == OFF_NOTIFY && req_r.write_data <= 32'd1) begin
        nv <= 1'b1;
        nq <= req_r.write_data[0];
      end
      if (is_write && !in_cfg && req_r.offset == OFF_STATUS && req_r.write_data == '0)
        drst <= 1'b1;
    end else if (cmd.rd_capture) begin
      rd_acc[{cnt[1:0], 3'b000} +: 8] <= mem_q;
    end
  end

  // Select and subselect mirrors follow writes to bytes 0 and 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_byte <= '0;
      sub_byte <= '0;
    end else if (cmd.wr_byte) begin
      if (mem_waddr == AW'(0)) sel_byte <= mem_wdata;
      if (mem_waddr == AW'(1)) sub_byte <= mem_wdata;
    end
  end

  // Memory write port: clearing sweep, bus byte writes, rebuild sweep.
  always_comb begin
    mem_we    = cmd.clear_en || cmd.wr_byte || cmd.rb_en;
    mem_waddr = cnt[AW-1:0];
    mem_wdata = '0;
    if (cmd.wr_byte) begin
      mem_waddr = c_off + AW'(cnt[1:0]);
      mem_wdata = req_r.write_data[{cnt[1:0], 3'b000} +: 8];
    end else if (cmd.rb_en) begin
      if (cnt == CW'(RB_BYTES)) begin
        mem_waddr = AW'(SIZE_POS);
        mem_wdata = rebuild_size(sel_byte, sub_byte, device_kind);
      end else begin
        mem_waddr = AW'(RB_BASE) + AW'(cnt[6:0]);
        mem_wdata = rebuild_byte(sel_byte, sub_byte, device_kind, axis_width, axis_height,
                                 cnt[6:0]);
      end
    end
  end

  assign mem_raddr = c_off + AW'(cnt[1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) cfg_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) mem_q <= cfg_mem[mem_raddr];
  end

  // Output register; a finished result waits here until transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.read_data    <= rd_acc;
      rsp.notify_valid <= nv;
      rsp.notify_queue <= nq;
      rsp.device_reset <= drst;
      rsp.irq_pending  <= irq_status != '0;
    end
  end

  // A status write of zero leaves no ready queue and no pending interrupt.
  a_status_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.reg_op && is_write && !in_cfg && req_r.offset == OFF_STATUS &&
     req_r.write_data == '0) |=> (queue_ready == '0 && irq_status == '0))
    else $error("device reset left state behind");

  // Byte accesses never run past the end of the config space.
  a_byte_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_byte || cmd.rd_issue) |-> ({1'b0, cnt[2:0]} < {1'b0, n_bytes}))
    else $error("config byte access beyond length");

  // The result register is loaded only when it is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || !rsp_stall))
    else $error("result overwritten before transfer");

endmodule

// ===== src/virtio_input_mmio_registers_unit.sv =====
// ---------------------------------------------------------------------------
// virtio_input_mmio_registers_unit: virtio-mmio input device register block
// Request channel (req_valid, req_stall, req) carries one bus access: read,
// write or queue completion. Response channel (rsp_valid, rsp_stall, rsp)
// returns exactly one result per request. A transfer happens on a clock edge
// with valid high and stall low. Configuration registers are to be written
// by the user through cfg_we, cfg_index and cfg_data only while no request
// is in flight; the block itself does not enforce this. Config reads and
// writes move one byte at a time through the single config memory port; a
// config write that covers the select or subselect byte is followed by the
// rebuild sweep. The next request can transfer at the edge at which the
// previous result first can transfer. One request is worked on at a time;
// the next is taken while the previous result waits in the output register.
// A stalled result holds and blocks only the handoff of the next.
// After reset the block clears the whole config space with req_stall high.
// ---------------------------------------------------------------------------
module virtio_input_mmio_registers_unit #(
  parameter int CONFIG_BYTES = vimr_pkg::CONFIG_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  vimr_pkg::vimr_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output vimr_pkg::vimr_rsp_t rsp
);
  import vimr_pkg::*;

  vimr_cmd_t  cmd;
  vimr_stat_t stat;

  assign req_stall = !cmd.idle;

  vimr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  vimr_dp #(
    .CONFIG_BYTES (CONFIG_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // The block is busy during the clearing sweep after reset.
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall)
    else $error("request taken during the clearing sweep");

  // One request at a time: a transfer is followed by a busy cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request taken while busy");

  // A notified queue index only comes with a notify.
  a_notify_queue: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.notify_queue || rsp.notify_valid))
    else $error("notify queue without notify");

endmodule
